[sv/window_coefficient_generator_defines.svh]
// ----------------------------------------------------------------------------
// Window coefficient generator assertion macros
// Immediate-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef WINDOW_COEFFICIENT_GENERATOR_DEFINES_SVH
`define WINDOW_COEFFICIENT_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define WCG_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define WCG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define WCG_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define WCG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

[sv/wcg_pkg.sv]
// ----------------------------------------------------------------------------
// Window coefficient generator package
// Widths, window codes, fixed-point constants and the pipeline control word.
// ----------------------------------------------------------------------------
package wcg_pkg;

	localparam int IDX_W          = 12;
	localparam int LEN_W          = 13;
	localparam int MM1_W          = 12;
	localparam int TYPE_W         = 3;
	localparam int CFG_IDX_W      = 1;
	localparam int CFG_DATA_W     = 13;
	localparam int MAX_LENGTH     = 4096;
	localparam int COEF_FRAC_BITS = 16;
	localparam int COEF_W         = COEF_FRAC_BITS + 1;
	localparam int PH_W           = 32;
	localparam int BQ_W           = 31;
	localparam int CORDIC_STEPS   = 28;
	localparam int CW             = 33;
	localparam int PROD_W         = 65;
	localparam int WW             = 35;

	typedef enum logic [TYPE_W-1:0] {
		WIN_RECT     = 3'd0,
		WIN_HAMMING  = 3'd1,
		WIN_BARTLETT = 3'd2,
		WIN_BLACKMAN = 3'd3,
		WIN_HANN     = 3'd4
	} win_type_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_TYPE   = 1'b0,
		REG_WINDOW_LENGTH = 1'b1
	} cfg_reg_t;

	localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;
	localparam logic signed [31:0] K054 = 32'sd579820585;
	localparam logic signed [31:0] K046 = 32'sd493921239;
	localparam logic signed [31:0] K042 = 32'sd450971566;
	localparam logic signed [31:0] K008 = 32'sd85899346;
	localparam logic signed [31:0] K050 = 32'sd536870912;
	localparam logic signed [WW-1:0] ONE_Q30 = 35'sd1073741824;

	localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
		32'h00000014, 32'h0000000A, 32'h00000005
	};

	typedef struct packed {
		logic              valid;
		logic [TYPE_W-1:0] wtype;
		logic              oor;
		logic              unity;
	} ctrl_t;

endpackage

[sv/wcg_if.sv]
// ----------------------------------------------------------------------------
// Window coefficient generator channels
// Index channel and coefficient channel, each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface wcg_index_if;
	logic                       valid;
	logic                       ready;
	logic [wcg_pkg::IDX_W-1:0]  sample_index;

	modport source (output valid, output sample_index, input ready);
	modport sink (input valid, input sample_index, output ready);
endinterface

interface wcg_coef_if;
	logic                       valid;
	logic                       ready;
	logic [wcg_pkg::COEF_W-1:0] coefficient;
	logic                       out_of_range;

	modport source (output valid, output coefficient, output out_of_range, input ready);
	modport sink (input valid, input coefficient, input out_of_range, output ready);
endinterface

[sv/window_coefficient_generator.sv]
// Throughput: one index per cycle; the whole pipeline holds while a result
// waits on a low ready, so nothing is lost or repeated.
// Reset (arst_n low, asynchronous) empties the pipeline and sets the window
// to rectangle with length 4096.
// ----------------------------------------------------------------------------
// Window coefficient generator
// Rectangle, Hamming, Bartlett, Blackman and Hann weights, one per index.
// ----------------------------------------------------------------------------
`include "window_coefficient_generator_defines.svh"

module window_coefficient_generator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [wcg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [wcg_pkg::CFG_DATA_W-1:0]  cfg_data,
	wcg_index_if.sink                       in_ch,
	wcg_coef_if.source                      out_ch
);
	import wcg_pkg::*;

	logic [TYPE_W-1:0] wtype_q;
	logic [LEN_W-1:0]  wlen_q;

	logic [LEN_W-1:0]  m;
	logic [MM1_W-1:0]  mm1;
	logic              en;
	ctrl_t             ctrl_in;
	ctrl_t             ctrl_div;
	ctrl_t             ctrl_cos;
	ctrl_t             ctrl_out;
	logic [PH_W-1:0]   phase;
	logic [BQ_W-1:0]   bart_div;
	logic [BQ_W-1:0]   bart_cos;
	logic signed [CW-1:0] cos1;
	logic signed [CW-1:0] cos2;
	logic [COEF_W-1:0] coef;

	// Configuration: user writes with no transaction in flight; not enforced.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wtype_q <= WIN_RECT;
			wlen_q  <= LEN_W'(MAX_LENGTH);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WINDOW_TYPE:   wtype_q <= cfg_data[TYPE_W-1:0];
				REG_WINDOW_LENGTH: wlen_q  <= cfg_data[LEN_W-1:0];
				default:           ;
			endcase
		end
	end

	// Saturate the length, then form M-1. Length zero puts every index
	// out of range, so M-1 is a don't-care there.
	assign m   = (wlen_q > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : wlen_q;
	assign mm1 = (m == '0) ? '0 : MM1_W'(m - 1'b1);

	// One enable for every stage: advance whenever the output register is
	// empty or its transaction is being taken this cycle.
	assign en          = !ctrl_out.valid || out_ch.ready;
	assign in_ch.ready = en;

	// Length one and the rectangle (plus the unused type codes) give 1.0.
	always_comb begin
		ctrl_in.valid = in_ch.valid;
		ctrl_in.wtype = wtype_q;
		ctrl_in.oor   = ({1'b0, in_ch.sample_index} >= m);
		ctrl_in.unity = (mm1 == '0) || (wtype_q == WIN_RECT) || (wtype_q > WIN_HANN);
	end

	// Phase n/(M-1) as a binary angle and the rounded triangle weight.
	wcg_phase_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.n        (in_ch.sample_index),
		.mm1      (mm1),
		.ctrl_in  (ctrl_in),
		.phase    (phase),
		.bart     (bart_div),
		.ctrl_out (ctrl_div)
	);

	// Cosine of the phase and of twice the phase.
	wcg_cordic u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.phase    (phase),
		.bart_in  (bart_div),
		.ctrl_in  (ctrl_div),
		.cos1     (cos1),
		.cos2     (cos2),
		.bart_out (bart_cos),
		.ctrl_out (ctrl_cos)
	);

	// Weight sum, clamp to 0..1.0 and round to the output format.
	wcg_combine u_combine (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.cos1     (cos1),
		.cos2     (cos2),
		.bart     (bart_cos),
		.ctrl_in  (ctrl_cos),
		.coef     (coef),
		.ctrl_out (ctrl_out)
	);

	assign out_ch.valid        = ctrl_out.valid;
	assign out_ch.coefficient  = coef;
	assign out_ch.out_of_range = ctrl_out.oor;

	`WCG_ASSERT_SAME(a_oor_zero, clk, arst_n, out_ch.valid && out_ch.out_of_range, out_ch.coefficient == '0, "out-of-range result with nonzero coefficient")
	`WCG_ASSERT_SAME(a_coef_max, clk, arst_n, out_ch.valid, out_ch.coefficient <= (COEF_W'(1) << COEF_FRAC_BITS), "coefficient above 1.0")
	`WCG_ASSERT_NEXT(a_stall_hold, clk, arst_n, !in_ch.ready, out_ch.valid, "stalled pipeline dropped its result")

endmodule

[sv/wcg_phase_div.sv]
// ----------------------------------------------------------------------------
// Phase and triangle divider
// Restoring division, one quotient bit per stage, for n/(M-1) and the
// triangle weight, run side by side.
// ----------------------------------------------------------------------------
module wcg_phase_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic [wcg_pkg::IDX_W-1:0] n,
	input  logic [wcg_pkg::MM1_W-1:0] mm1,
	input  wcg_pkg::ctrl_t            ctrl_in,
	output logic [wcg_pkg::PH_W-1:0]  phase,
	output logic [wcg_pkg::BQ_W-1:0]  bart,
	output wcg_pkg::ctrl_t            ctrl_out
);
	import wcg_pkg::*;

	localparam int STEPS = PH_W;
	localparam int BSTEPS = BQ_W - 1;

	logic [MM1_W-1:0] rp_s [STEPS+1];
	logic [PH_W-1:0]  qp_s [STEPS+1];
	logic [MM1_W-1:0] rb_s [STEPS+1];
	logic [BQ_W-1:0]  qb_s [STEPS+1];
	ctrl_t            c_s  [STEPS+1];

	logic [MM1_W+1:0] diff;
	logic [MM1_W+1:0] absd;
	logic [MM1_W+1:0] num;
	logic [MM1_W-1:0] num_lo;
	logic [BSTEPS-1:0] half;

	// triangle numerator: (M-1) - |2n - (M-1)|
	assign diff   = {1'b0, n, 1'b0} - {2'b00, mm1};
	assign absd   = diff[MM1_W+1] ? (~diff + 1'b1) : diff;
	assign num    = {2'b00, mm1} - absd;
	assign num_lo = num[MM1_W-1:0];
	assign half   = BSTEPS'(mm1 >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_s[0] <= '0;
		end else if (en) begin
			c_s[0] <= ctrl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rp_s[0] <= (n == mm1) ? '0 : n;
			qp_s[0] <= '0;
			rb_s[0] <= (num_lo == mm1) ? '0 : num_lo;
			qb_s[0] <= {(num_lo == mm1), {(BQ_W-1){1'b0}}};
		end
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic [MM1_W:0] tp;
		logic           gp;

		assign tp = {rp_s[k], 1'b0};
		assign gp = (tp >= {1'b0, mm1});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				c_s[k+1] <= '0;
			end else if (en) begin
				c_s[k+1] <= c_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rp_s[k+1] <= gp ? MM1_W'(tp - {1'b0, mm1}) : tp[MM1_W-1:0];
				qp_s[k+1] <= qp_s[k] | (PH_W'(gp) << (PH_W-1-k));
			end
		end

		if (k < BSTEPS) begin : g_bart
			logic [MM1_W:0] tb;
			logic           gb;

			assign tb = {rb_s[k], half[BSTEPS-1-k]};
			assign gb = (tb >= {1'b0, mm1});

			always_ff @(posedge clk) begin
				if (en) begin
					rb_s[k+1] <= gb ? MM1_W'(tb - {1'b0, mm1}) : tb[MM1_W-1:0];
					qb_s[k+1] <= qb_s[k] | (BQ_W'(gb) << (BSTEPS-1-k));
				end
			end
		end else begin : g_hold
			always_ff @(posedge clk) begin
				if (en) begin
					rb_s[k+1] <= rb_s[k];
					qb_s[k+1] <= qb_s[k];
				end
			end
		end
	end

	assign phase    = qp_s[STEPS];
	assign bart     = qb_s[STEPS];
	assign ctrl_out = c_s[STEPS];

endmodule

[sv/wcg_cordic.sv]
// ----------------------------------------------------------------------------
// Cosine pipeline
// Two lanes of rotation-mode CORDIC, one step per stage, for the phase
// and twice the phase.
// ----------------------------------------------------------------------------
module wcg_cordic (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic [wcg_pkg::PH_W-1:0]        phase,
	input  logic [wcg_pkg::BQ_W-1:0]        bart_in,
	input  wcg_pkg::ctrl_t                  ctrl_in,
	output logic signed [wcg_pkg::CW-1:0]   cos1,
	output logic signed [wcg_pkg::CW-1:0]   cos2,
	output logic [wcg_pkg::BQ_W-1:0]        bart_out,
	output wcg_pkg::ctrl_t                  ctrl_out
);
	import wcg_pkg::*;

	localparam int DEPTH = CORDIC_STEPS + 2;

	logic [PH_W-1:0]      ang [2];
	logic signed [CW-1:0] cos_s [2];
	logic [BQ_W-1:0]      b_s [DEPTH];
	ctrl_t                c_s [DEPTH];

	assign ang[0] = phase;
	assign ang[1] = {phase[PH_W-2:0], 1'b0};

	for (genvar d = 0; d < DEPTH; d++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				c_s[d] <= '0;
			end else if (en) begin
				c_s[d] <= (d == 0) ? ctrl_in : c_s[(d == 0) ? 0 : d-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				b_s[d] <= (d == 0) ? bart_in : b_s[(d == 0) ? 0 : d-1];
			end
		end
	end

	for (genvar l = 0; l < 2; l++) begin : g_lane
		logic signed [CW-1:0] x_s [CORDIC_STEPS+1];
		logic signed [CW-1:0] y_s [CORDIC_STEPS+1];
		logic signed [CW-1:0] z_s [CORDIC_STEPS+1];
		logic                 f_s [CORDIC_STEPS+1];
		logic [PH_W-1:0]      rot;
		logic [PH_W-1:0]      tt;
		logic                 flip;

		// fold the left half-plane onto the right, negate at the end
		assign rot  = ang[l] + 32'h4000_0000;
		assign flip = rot[PH_W-1];
		assign tt   = flip ? (ang[l] - 32'h8000_0000) : ang[l];

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[0] <= CORDIC_GAIN;
				y_s[0] <= '0;
				z_s[0] <= {tt[PH_W-1], tt};
				f_s[0] <= flip;
			end
		end

		for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_it
			logic signed [CW-1:0] dx;
			logic signed [CW-1:0] dy;
			logic signed [CW-1:0] at;

			assign dx = y_s[k] >>> k;
			assign dy = x_s[k] >>> k;
			assign at = {1'b0, ATAN_TURNS[k]};

			always_ff @(posedge clk) begin
				if (en) begin
					f_s[k+1] <= f_s[k];
					if (!z_s[k][CW-1]) begin
						x_s[k+1] <= x_s[k] - dx;
						y_s[k+1] <= y_s[k] + dy;
						z_s[k+1] <= z_s[k] - at;
					end else begin
						x_s[k+1] <= x_s[k] + dx;
						y_s[k+1] <= y_s[k] - dy;
						z_s[k+1] <= z_s[k] + at;
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cos_s[l] <= f_s[CORDIC_STEPS] ? -x_s[CORDIC_STEPS] : x_s[CORDIC_STEPS];
			end
		end
	end

	assign cos1     = cos_s[0];
	assign cos2     = cos_s[1];
	assign bart_out = b_s[DEPTH-1];
	assign ctrl_out = c_s[DEPTH-1];

endmodule

[sv/wcg_combine.sv]
// ----------------------------------------------------------------------------
// Window combiner
// Weight products, term sum per window type, clamp and output rounding.
// ----------------------------------------------------------------------------
module wcg_combine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic signed [wcg_pkg::CW-1:0] cos1,
	input  logic signed [wcg_pkg::CW-1:0] cos2,
	input  logic [wcg_pkg::BQ_W-1:0]      bart,
	input  wcg_pkg::ctrl_t                ctrl_in,
	output logic [wcg_pkg::COEF_W-1:0]    coef,
	output wcg_pkg::ctrl_t                ctrl_out
);
	import wcg_pkg::*;

	localparam int SHIFT = 30 - COEF_FRAC_BITS;
	localparam logic signed [PROD_W-1:0] HALF_Q30 = 65'sd536870912;
	localparam logic [30:0] RND = 31'(1) << (SHIFT - 1);

	logic signed [31:0]     kmul;
	logic signed [31:0]     base;

	logic signed [PROD_W-1:0] m1_s1;
	logic signed [PROD_W-1:0] m2_s1;
	logic signed [31:0]       base_s1;
	logic [BQ_W-1:0]          bart_s1;
	ctrl_t                    c_s1;

	logic signed [PROD_W-1:0] r1;
	logic signed [PROD_W-1:0] r2;
	logic signed [WW-1:0]     w_s2;
	ctrl_t                    c_s2;

	logic [30:0]              clamped;
	logic [COEF_W-1:0]        coef_s3;
	ctrl_t                    c_s3;

	always_comb begin
		kmul = K050;
		base = K050;
		unique case (ctrl_in.wtype)
			WIN_HAMMING:  begin kmul = K046; base = K054; end
			WIN_BLACKMAN: begin kmul = K050; base = K042; end
			default:      begin kmul = K050; base = K050; end
		endcase
	end

	assign r1 = (m1_s1 + HALF_Q30) >>> 30;
	assign r2 = (m2_s1 + HALF_Q30) >>> 30;

	always_comb begin
		if (w_s2[WW-1]) begin
			clamped = '0;
		end else if (w_s2 > ONE_Q30) begin
			clamped = ONE_Q30[30:0];
		end else begin
			clamped = w_s2[30:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_s1 <= '0;
			c_s2 <= '0;
			c_s3 <= '0;
		end else if (en) begin
			c_s1 <= ctrl_in;
			c_s2 <= c_s1;
			c_s3 <= c_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m1_s1   <= kmul * cos1;
			m2_s1   <= K008 * cos2;
			base_s1 <= base;
			bart_s1 <= bart;

			if (c_s1.unity) begin
				w_s2 <= ONE_Q30;
			end else if (c_s1.wtype == WIN_BARTLETT) begin
				w_s2 <= WW'({1'b0, bart_s1});
			end else if (c_s1.wtype == WIN_BLACKMAN) begin
				w_s2 <= WW'(base_s1) - WW'(r1) + WW'(r2);
			end else begin
				w_s2 <= WW'(base_s1) - WW'(r1);
			end

			coef_s3 <= c_s2.oor ? '0 : COEF_W'((clamped + RND) >> SHIFT);
		end
	end

	assign coef     = coef_s3;
	assign ctrl_out = c_s3;

endmodule

[tb/window_coefficient_generator_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Window coefficient generator testbench
// Drives sample indices through the valid/ready channels under a series of
// window type and length settings, predicts each coefficient with a local
// CORDIC-based model, and checks every returned transaction in order.
// ----------------------------------------------------------------------------
module window_coefficient_generator_tb;
	import wcg_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 80;

	typedef struct {
		logic [COEF_W-1:0] coefficient;
		logic              out_of_range;
	} weight_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	wcg_index_if idx_ch ();
	wcg_coef_if  coef_ch ();

	window_coefficient_generator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (idx_ch.sink),
		.out_ch    (coef_ch.source)
	);

	// Local copy of the configuration, updated together with each register write.
	logic [TYPE_W-1:0] cur_type;
	logic [LEN_W-1:0]  cur_length;

	logic [IDX_W-1:0] pending_indices [$];
	weight_t          expected_weights [$];

	int  mismatches;
	bit  failed;
	bit  quiet;          // no idling on either side in the final stretch
	int  send_gap;
	int  recv_gap;
	int  idle_cycles;

	always #6 clk = ~clk;

	// Cosine of a binary-angle phase in Q30, by rotation-mode CORDIC.
	function automatic longint cordic_cos(logic [31:0] phase);
		logic   flip;
		longint x;
		longint y;
		longint z;
		longint dx;
		longint dy;
		logic [31:0] p;
		p    = phase;
		flip = p[31] ^ p[30];  // phase in [1/4, 3/4) turn
		if (flip)
			p = p - 32'h80000000;
		z = longint'($signed(p));
		x = longint'(CORDIC_GAIN);
		y = 0;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx; y = y + dy; z = z - longint'(ATAN_TURNS[i]);
			end else begin
				x = x + dx; y = y - dy; z = z + longint'(ATAN_TURNS[i]);
			end
		end
		return flip ? -x : x;
	endfunction

	function automatic longint scale_q30(longint k, longint c);
		return (k * c + (longint'(1) << 29)) >>> 30;
	endfunction

	// Expected coefficient for one index under the current window setting.
	function automatic weight_t predict_weight(logic [TYPE_W-1:0] wtype,
		logic [LEN_W-1:0] len, logic [IDX_W-1:0] idx);
		weight_t     r;
		longint      m;
		longint      mm1;
		longint      n;
		longint      w;
		longint      d;
		logic [63:0] ph;
		logic [31:0] t1;
		longint      c1;
		longint      c2;
		m = (len > MAX_LENGTH) ? MAX_LENGTH : len;
		n = idx;
		if (n >= m) begin
			r.coefficient  = '0;
			r.out_of_range = 1'b1;
			return r;
		end
		mm1 = m - 1;
		if (mm1 == 0 || wtype == WIN_RECT || wtype > WIN_HANN) begin
			w = ONE_Q30;
		end else if (wtype == WIN_BARTLETT) begin
			d = 2 * n - mm1;
			if (d < 0)
				d = -d;
			w = (((mm1 - d) << 30) + mm1 / 2) / mm1;
		end else begin
			ph = (64'(n) << 32) / 64'(mm1);
			t1 = ph[31:0];
			c1 = cordic_cos(t1);
			if (wtype == WIN_HAMMING)
				w = longint'(K054) - scale_q30(K046, c1);
			else if (wtype == WIN_HANN)
				w = longint'(K050) - scale_q30(K050, c1);
			else begin
				c2 = cordic_cos({t1[30:0], 1'b0});
				w = longint'(K042) - scale_q30(K050, c1) + scale_q30(K008, c2);
			end
		end
		if (w < 0)
			w = 0;
		if (w > ONE_Q30)
			w = ONE_Q30;
		w = (w + (longint'(1) << (29 - COEF_FRAC_BITS))) >>> (30 - COEF_FRAC_BITS);
		r.coefficient  = w[COEF_W-1:0];
		r.out_of_range = 1'b0;
		return r;
	endfunction

	// Index driver: hold valid until accepted, then advance or insert a gap.
	always @(posedge clk) begin
		if (arst_n) begin
			if (idx_ch.valid && idx_ch.ready)
				expected_weights.push_back(
					predict_weight(cur_type, cur_length, idx_ch.sample_index));
			if (!idx_ch.valid || idx_ch.ready) begin
				if (send_gap > 0) begin
					idx_ch.valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (pending_indices.size() > 0 && !quiet &&
					$urandom_range(0, 9) == 0) begin
					idx_ch.valid <= 1'b0;
					send_gap <= $urandom_range(0, 13);
				end else if (pending_indices.size() > 0) begin
					idx_ch.valid <= 1'b1;
					idx_ch.sample_index <= pending_indices.pop_front();
				end else begin
					idx_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Coefficient monitor: compare each transaction with the oldest prediction.
	always @(posedge clk) begin
		weight_t exp_w;
		if (arst_n) begin
			if (coef_ch.valid && coef_ch.ready) begin
				if (expected_weights.size() == 0) begin
					failed = 1'b1;
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected coefficient %0d oor %0b",
							coef_ch.coefficient, coef_ch.out_of_range);
				end else begin
					exp_w = expected_weights.pop_front();
					if (coef_ch.coefficient !== exp_w.coefficient ||
						coef_ch.out_of_range !== exp_w.out_of_range) begin
						failed = 1'b1;
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected coef %0d oor %0b, got coef %0d oor %0b",
								exp_w.coefficient, exp_w.out_of_range,
								coef_ch.coefficient, coef_ch.out_of_range);
					end
				end
			end
			// Stall the output side in random bursts.
			if (recv_gap > 0) begin
				coef_ch.ready <= 1'b0;
				recv_gap <= recv_gap - 1;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				coef_ch.ready <= 1'b0;
				recv_gap <= $urandom_range(0, 13);
			end else begin
				coef_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog: count cycles with work pending but no transaction on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((idx_ch.valid && idx_ch.ready) || (coef_ch.valid && coef_ch.ready) ||
				(pending_indices.size() == 0 && !idx_ch.valid &&
				expected_weights.size() == 0))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// Sample at the falling edge so the driver's updates have settled.
	task automatic wait_drained();
		@(negedge clk);
		while (pending_indices.size() > 0 || idx_ch.valid || expected_weights.size() > 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write both registers while the pipeline is empty.
	task automatic set_window(logic [CFG_DATA_W-1:0] type_word, logic [CFG_DATA_W-1:0] len_word);
		wait_drained();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_WINDOW_TYPE;
		cfg_data  <= type_word;
		cur_type  <= type_word[TYPE_W-1:0];
		@(posedge clk);
		cfg_index  <= REG_WINDOW_LENGTH;
		cfg_data   <= len_word;
		cur_length <= len_word[LEN_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int          total;
		int          count;
		int          span;
		logic [12:0] len_word;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_WINDOW_TYPE;
		cfg_data = '0;
		idx_ch.valid = 1'b0;
		idx_ch.sample_index = '0;
		coef_ch.ready = 1'b0;
		cur_type = WIN_RECT;
		cur_length = 13'(MAX_LENGTH);
		mismatches = 0;
		failed = 1'b0;
		quiet = 1'b0;
		send_gap = 0;
		recv_gap = 0;
		idle_cycles = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset setting, then each window at its extremes.
		pending_indices = '{12'd0, 12'd4095};
		set_window(WIN_HAMMING, 13'd4096);
		pending_indices = '{12'd0, 12'd1, 12'd2048, 12'd4095};
		set_window(WIN_BARTLETT, 13'd4095);
		pending_indices = '{12'd0, 12'd2047, 12'd4094, 12'd4095};
		set_window(WIN_BLACKMAN, 13'd4096);
		pending_indices = '{12'd0, 12'd1024, 12'd2048, 12'd4095};
		set_window(WIN_HANN, 13'd2);
		pending_indices = '{12'd0, 12'd1, 12'd2};
		// Length one gives unity, length zero is all out of range.
		set_window(WIN_BLACKMAN, 13'd1);
		pending_indices = '{12'd0, 12'd1};
		set_window(WIN_HANN, 13'd0);
		pending_indices = '{12'd0, 12'd4095};
		// Oversized length saturates; type seven acts as rectangle.
		set_window(13'h1FFF, 13'h1FFF);
		pending_indices = '{12'd4095, 12'd100};

		total = 0;
		while (total < 1650) begin
			case ($urandom_range(0, 3))
				0: len_word = 13'($urandom_range(0, 16));
				1: len_word = 13'($urandom_range(4090, 8191));
				default: len_word = 13'($urandom_range(0, 8191));
			endcase
			count = $urandom_range(60, 150);
			if (total + count >= 1650)
				count = 1650 - total;
			set_window(13'($urandom), len_word);
			if (total + count >= 1650)
				quiet = 1'b1;
			span = (len_word > MAX_LENGTH) ? MAX_LENGTH : len_word;
			for (int i = 0; i < count; i++) begin
				if (span > 0 && $urandom_range(0, 3) != 0)
					pending_indices.push_back(12'($urandom_range(0, span - 1)));
				else
					pending_indices.push_back(12'($urandom));
			end
			total += count;
		end

		wait_drained();
		if (!failed && expected_weights.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

[filelist.f]
+incdir+sv
sv/wcg_pkg.sv
sv/wcg_if.sv
sv/wcg_phase_div.sv
sv/wcg_cordic.sv
sv/wcg_combine.sv
sv/window_coefficient_generator.sv
tb/window_coefficient_generator_tb.sv
